### hw/rtl/assert_macros.svh
// Assertion macros shared by the touch pressure RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clk edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
// Condition that must never be seen on a rising clk edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### hw/rtl/tspr_pkg.sv
// Types, constants and helpers for the touch sample pressure report block.
package tspr_pkg;

	// Measurement bits actually used from each raw field
	localparam int SAMPLE_BITS = 16;
	localparam int SMP_W       = 16;
	localparam int TMR_W       = 16;

	// Register indexes on the config channel
	localparam int CFG_IDX_W = 2;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_INV_X   = 2'd0;
	localparam cfg_idx_t REG_INV_Y   = 2'd1;
	localparam cfg_idx_t REG_TIMEOUT = 2'd2;
	localparam logic [TMR_W-1:0] TIMEOUT_RST = 16'd70;

	// Request type codes
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	// Divider geometry: |(z2-z1-2)*x| < 2^32, z1+2 <= 65537
	localparam int DIV_W     = 32;
	localparam int DVS_W     = 17;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// Pressure scaling: (2500 - q) * 1000 / 1600 == (2500 - q) * 5 / 8
	localparam int PRESS_W     = 31;
	localparam int T_W         = 34;
	localparam int PRESS_FULL  = 2500;
	localparam int SCALE_MUL   = 5;
	localparam int SCALE_SHIFT = 3;
	localparam int PRESS_SAT   = 255;

	typedef struct packed {
		logic             req_type;
		logic             from_sample_line;
		logic             pen_up_flag;
		logic             data_valid_flag;
		logic [SMP_W-1:0] raw_x;
		logic [SMP_W-1:0] raw_y;
		logic [SMP_W-1:0] raw_z1;
		logic [SMP_W-1:0] raw_z2;
	} req_t;

	typedef struct packed {
		logic               touch_active;
		logic               has_position;
		logic [SMP_W-1:0]   pos_x;
		logic [SMP_W-1:0]   pos_y;
		logic [PRESS_W-1:0] pressure;
	} rpt_t;

	typedef struct packed {
		logic tick;
		logic stop;
		logic arm;
	} timer_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	function automatic logic [SMP_W-1:0] smp_mask(input logic [SMP_W-1:0] v);
		logic [SMP_W:0] m;
		m = (SMP_W+1)'((33'd1 << SAMPLE_BITS) - 33'd1);
		return v & m[SMP_W-1:0];
	endfunction

endpackage

### hw/rtl/tspr_if.sv
// Valid/ready channel interfaces for requests, reports and config writes.
interface tspr_req_if import tspr_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tspr_rpt_if import tspr_pkg::*; ();
	logic valid;
	logic ready;
	rpt_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tspr_cfg_if import tspr_pkg::*; ();
	logic             valid;
	logic             ready;
	cfg_idx_t         index;
	logic [SMP_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

### hw/rtl/tspr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`include "assert_macros.svh"
module tspr_div import tspr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [DIV_W-1:0] quotient,
	output div_sts_t         sts
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DVS_W-1:0]     dvs_q;

	logic [DVS_W:0]   shifted;
	logic [DVS_W+1:0] trial;
	logic             ge;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
	assign ge      = !trial[DVS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign sts      = '{busy: busy_q, done: done_q};

	`ASSERT_NEVER(a_div_start_busy, start && busy_q, "divider restarted mid-division")
	`ASSERT_PROP(a_div_done_end, $fell(busy_q) |-> done_q, "division ended without done")

endmodule

### hw/rtl/tspr_timer.sv
// Pen-up timeout counter, decremented by millisecond ticks.
`include "assert_macros.svh"
module tspr_timer import tspr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  timer_cmd_t       cmd,
	input  logic [TMR_W-1:0] load_val,
	output logic             expire
);

	logic             armed_q;
	logic [TMR_W-1:0] rem_q;

	// zero or one left: this tick ends the timeout
	assign expire = cmd.tick && armed_q && (rem_q <= TMR_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			rem_q   <= '0;
		end else if (cmd.tick && armed_q) begin
			if (rem_q <= TMR_W'(1)) begin
				armed_q <= 1'b0;
				rem_q   <= '0;
			end else begin
				rem_q <= rem_q - 1'b1;
			end
		end else if (cmd.stop) begin
			armed_q <= cmd.arm;
			if (cmd.arm)
				rem_q <= load_val;
		end
	end

	`ASSERT_PROP(a_tmr_expire_clear, expire |=> !armed_q && rem_q == '0, "timer still armed")

endmodule

### hw/rtl/touch_sample_pressure_report.sv
// Top level: touch sample sequencer, config registers and report register.
//
// Channel  Dir  Beat carries
// -------  ---  ------------------------------------------------------------
// cfg      in   register index + 16-bit write data (always ready)
// req      in   sample event (flags, raw X/Y/Z1/Z2) or millisecond tick
// rpt      out  touch state, position and pressure
//
// A pen-down sample with valid data runs through the states MUL, LOAD, DIV,
// SCALE, PRESS and EMIT; in DIV the shared one-bit-per-cycle divider
// forms (Z2-Z1-2)*X/(Z1+2). Expiring ticks and pen-up samples go straight to EMIT,
// and items with no report stay in idle. req is not ready while an item is being worked.
// The report register holds one beat; while it is stalled the next item is
// still taken and worked, then waits for the slot. Reset is asynchronous,
// active low, and clears the timer, the sequencer and the report valid.
`include "assert_macros.svh"
module touch_sample_pressure_report import tspr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	tspr_cfg_if.sink    cfg,
	tspr_req_if.sink    req,
	tspr_rpt_if.source  rpt
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_LOAD  = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_SCALE = 3'd4;
	localparam logic [2:0] S_PRESS = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	// config registers
	logic [SMP_W-1:0] inv_x_q;
	logic [SMP_W-1:0] inv_y_q;
	logic [TMR_W-1:0] timeout_q;

	logic [2:0] state_q;

	// working registers of the current sample
	logic [SMP_W-1:0] x_q;
	logic [DVS_W-1:0] z1p2_q;
	logic [DVS_W-1:0] dmag_q;   // |z2 - z1 - 2|
	logic             neg_q;    // z2 - z1 - 2 < 0
	logic [DIV_W-1:0] prod_q;
	logic [T_W-1:0]   t_q;      // 2500 - q, signed
	rpt_t             res_q;

	logic rpt_valid_q;
	rpt_t rpt_q;

	logic             acc;
	logic             is_tick;
	logic             down;
	logic             smp_down;
	logic             report;
	logic [SMP_W-1:0] mx;
	logic [SMP_W-1:0] my;
	logic [SMP_W-1:0] mz1;
	logic [SMP_W-1:0] mz2;
	logic [SMP_W+1:0] diff;
	logic [DIV_W:0]   prod;
	logic [DIV_W-1:0] quot;
	logic [T_W+2:0]   t5;
	logic [PRESS_W-1:0] zc;
	logic             rpt_load;
	logic             expire;
	timer_cmd_t       tcmd;
	div_sts_t         div_sts;

	function automatic logic [SMP_W-1:0] mirror(input logic [SMP_W-1:0] v,
			input logic [SMP_W-1:0] ref_v);
		logic [SMP_W-1:0] r;
		if (ref_v == '0)
			r = v;
		else if (ref_v >= v)
			r = ref_v - v;
		else
			r = '0;
		return r;
	endfunction

	// ---------------- config port ----------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_x_q   <= '0;
			inv_y_q   <= '0;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_INV_X:   inv_x_q   <= cfg.data;
				REG_INV_Y:   inv_y_q   <= cfg.data;
				REG_TIMEOUT: timeout_q <= cfg.data;
				default:     ;
			endcase
		end
	end

	// ---------------- request decode ----------------
	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign is_tick   = (req.data.req_type == REQ_TICK);
	assign down      = !req.data.pen_up_flag;
	assign smp_down  = !is_tick && down;
	assign report    = !down || req.data.data_valid_flag;

	assign mx   = smp_mask(req.data.raw_x);
	assign my   = smp_mask(req.data.raw_y);
	assign mz1  = smp_mask(req.data.raw_z1);
	assign mz2  = smp_mask(req.data.raw_z2);
	assign diff = {2'b00, mz2} - {2'b00, mz1} - (SMP_W+2)'(2);

	// Every sample stops the timer; a reporting sample on the sample line re-arms it.
	assign tcmd.tick = acc && is_tick;
	assign tcmd.stop = acc && !is_tick;
	assign tcmd.arm  = acc && !is_tick && report && req.data.from_sample_line;

	tspr_timer u_timer (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (tcmd),
		.load_val (timeout_q),
		.expire   (expire)
	);

	// ---------------- shared divider ----------------
	tspr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_LOAD),
		.dividend (prod_q),
		.divisor  (z1p2_q),
		.quotient (quot),
		.sts      (div_sts)
	);

	// unsigned 17x16 magnitude product, always below 2^32
	assign prod = (DIV_W+1)'(dmag_q) * (DIV_W+1)'(x_q);

	// z = trunc(5t/8); non-positive z saturates to 255
	assign t5 = (T_W+3)'(t_q[T_W-2:0]) * (T_W+3)'(SCALE_MUL);
	assign zc = t5[SCALE_SHIFT +: PRESS_W];

	// ---------------- sequencer ----------------
	assign rpt_load = (state_q == S_EMIT) && (!rpt_valid_q || rpt.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (is_tick)
							state_q <= expire ? S_EMIT : S_IDLE;
						else if (!down)
							state_q <= S_EMIT;
						else if (report)
							state_q <= S_MUL;
					end
				end
				S_MUL:   state_q <= S_LOAD;
				S_LOAD:  state_q <= S_DIV;
				S_DIV:   if (div_sts.done) state_q <= S_SCALE;
				S_SCALE: state_q <= S_PRESS;
				S_PRESS: state_q <= S_EMIT;
				S_EMIT:  if (rpt_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					// touch-up and expiry beats carry all-zero fields
					res_q <= '{touch_active: smp_down,
						has_position: smp_down,
						pos_x:        smp_down ? mirror(mx, inv_x_q) : '0,
						pos_y:        smp_down ? mirror(my, inv_y_q) : '0,
						pressure:     '0};
					x_q    <= mx;
					z1p2_q <= {1'b0, mz1} + DVS_W'(2);
					neg_q  <= diff[SMP_W+1];
					dmag_q <= diff[SMP_W+1] ? DVS_W'(-diff) : diff[DVS_W-1:0];
				end
			end
			S_MUL: prod_q <= prod[DIV_W-1:0];
			S_SCALE: begin
				if (neg_q)
					t_q <= T_W'(PRESS_FULL) + {2'b00, quot};
				else
					t_q <= T_W'(PRESS_FULL) - {2'b00, quot};
			end
			S_PRESS: begin
				if (t_q[T_W-1] || zc == '0)
					res_q.pressure <= PRESS_W'(PRESS_SAT);
				else
					res_q.pressure <= zc;
			end
			default: ;
		endcase
	end

	// ---------------- report register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rpt_valid_q <= 1'b0;
		else if (rpt_load)
			rpt_valid_q <= 1'b1;
		else if (rpt.ready)
			rpt_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (rpt_load)
			rpt_q <= res_q;
	end

	assign rpt.valid = rpt_valid_q;
	assign rpt.data  = rpt_q;

	`ASSERT_PROP(a_top_div_in_div, div_sts.busy |-> state_q == S_DIV, "divider busy outside S_DIV")
	`ASSERT_PROP(a_top_done_in_div, div_sts.done |-> state_q == S_DIV, "stray divider done")

endmodule

### sim/testbench.sv
// Self-checking testbench for the touch sample pressure report block.
`timescale 1ns / 100ps

module testbench;
	import tspr_pkg::*;

	// Run length and timing
	localparam int           CYCLE_LIMIT     = 1_000_000;
	localparam int           SETTLE_CYCLES   = 60;   // outlasts the pen-down path
	localparam int           HOLD_OFF_CYCLES = 600;
	localparam int           PHASE_COUNT     = 6;
	localparam int           PHASE_ITEMS     = 205;
	localparam longint       RAW_MASK        = (64'sd1 << SAMPLE_BITS) - 1;
	// Index 3 is decoded by nothing; a write to it must leave every register alone
	localparam cfg_idx_t     REG_UNUSED      = 2'd3;

	// How a directed row's report is judged
	typedef enum logic [1:0] {
		WANT_MODEL,  // whatever the predictor works out
		WANT_FIXED,  // typed-in report
		WANT_NONE    // no report at all
	} want_e;

	typedef struct packed {
		logic             is_cfg;
		want_e            want;
		req_t             item;
		rpt_t             fixed;
		cfg_idx_t         reg_idx;
		logic [SMP_W-1:0] reg_val;
	} dir_row_t;

	logic clk;
	logic arst_n;

	tspr_cfg_if cfg_if ();
	tspr_req_if req_if ();
	tspr_rpt_if rpt_if ();

	touch_sample_pressure_report DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.req    (req_if),
		.rpt    (rpt_if)
	);

	// Predictor copy of the registers and of the pen-up timer
	logic [SMP_W-1:0] cfg_inv_x   = '0;
	logic [SMP_W-1:0] cfg_inv_y   = '0;
	logic [TMR_W-1:0] cfg_timeout = TIMEOUT_RST;
	logic             tmr_armed   = 1'b0;
	logic [TMR_W-1:0] tmr_left    = '0;

	rpt_t pending_reports[$];
	int   fail_count   = 0;
	int   cycle_count  = 0;

	// Traffic shaping, owned by the stimulus process
	bit   steady       = 1'b0;  // no sender gaps
	bit   sink_stalls  = 1'b1;  // receiver stalls on its own pattern
	bit   hold_off_req = 1'b0;  // receiver holds ready low for a long stretch
	int   burst_left   = 0;

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Optional mirror about a reference, clamped at zero
	function automatic logic [SMP_W-1:0] mirror_pos(input logic [SMP_W-1:0] v,
			input logic [SMP_W-1:0] axis_ref);
		longint m;
		m = longint'(v) & RAW_MASK;
		if (axis_ref != '0)
			m = longint'(axis_ref) - m;
		if (m < 0)
			m = 0;
		return m[SMP_W-1:0];
	endfunction

	// Advances the timer copy by one request beat; returns 1 with the report
	// when the beat causes one.
	function automatic bit predict_report(input req_t it, output rpt_t r);
		longint sx, sz1, sz2, q, z;
		r = '0;
		if (it.req_type == REQ_TICK) begin
			if (!tmr_armed)
				return 1'b0;
			if (tmr_left <= 1) begin
				// expiry: synthetic touch-up, all fields zero
				tmr_armed = 1'b0;
				tmr_left  = '0;
				return 1'b1;
			end
			tmr_left = tmr_left - 1'b1;
			return 1'b0;
		end
		// any sample stops the timer, even one that reports nothing
		tmr_armed = 1'b0;
		if (!it.pen_up_flag && !it.data_valid_flag)
			return 1'b0;
		if (!it.pen_up_flag) begin
			sx  = longint'(it.raw_x) & RAW_MASK;
			sz1 = longint'(it.raw_z1) & RAW_MASK;
			sz2 = longint'(it.raw_z2) & RAW_MASK;
			// signed 64-bit division truncates toward zero, as required
			q = ((sz2 - sz1 - 2) * sx) / (sz1 + 2);
			z = ((2500 - q) * 1000) / (2500 - 900);
			if (z <= 0)
				z = 255;
			r.touch_active = 1'b1;
			r.has_position = 1'b1;
			r.pos_x        = mirror_pos(it.raw_x, cfg_inv_x);
			r.pos_y        = mirror_pos(it.raw_y, cfg_inv_y);
			r.pressure     = z[PRESS_W-1:0];
		end
		if (it.from_sample_line) begin
			tmr_armed = 1'b1;
			tmr_left  = cfg_timeout;
		end
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic req_t sample_req(input logic line, input logic up, input logic dv,
			input logic [SMP_W-1:0] x, input logic [SMP_W-1:0] y,
			input logic [SMP_W-1:0] z1, input logic [SMP_W-1:0] z2);
		req_t it;
		it.req_type         = REQ_SAMPLE;
		it.from_sample_line = line;
		it.pen_up_flag      = up;
		it.data_valid_flag  = dv;
		it.raw_x            = x;
		it.raw_y            = y;
		it.raw_z1           = z1;
		it.raw_z2           = z2;
		return it;
	endfunction

	function automatic req_t tick_req();
		req_t it;
		it          = '0;
		it.req_type = REQ_TICK;
		return it;
	endfunction

	function automatic rpt_t report(input logic act, input logic hp,
			input logic [SMP_W-1:0] x, input logic [SMP_W-1:0] y,
			input logic [PRESS_W-1:0] p);
		rpt_t r;
		r.touch_active = act;
		r.has_position = hp;
		r.pos_x        = x;
		r.pos_y        = y;
		r.pressure     = p;
		return r;
	endfunction

	// Raw measurement, weighted toward the ends of the range
	function automatic logic [SMP_W-1:0] rand_raw();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return SMP_W'($urandom_range(0, 15));
			default: return SMP_W'($urandom);
		endcase
	endfunction

	function automatic req_t rand_sample(input logic up, input logic dv);
		return sample_req(logic'($urandom_range(0, 3) != 0), up, dv,
			rand_raw(), rand_raw(), rand_raw(), rand_raw());
	endfunction

	// Offers one request beat (entered and left at a falling edge). The
	// expectation is queued at the edge that takes the beat.
	task automatic send_beat(input req_t it, input want_e want, input rpt_t fixed);
		int   gap;
		rpt_t r;
		bit   has;
		gap = 0;
		if (!steady) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 15);
				gap        = $urandom_range(1, 12);
			end
		end
		if (gap > 0) begin
			req_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.data  = it;
		req_if.valid = 1'b1;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		has = predict_report(it, r);
		case (want)
			WANT_MODEL: if (has) pending_reports.push_back(r);
			WANT_FIXED: pending_reports.push_back(fixed);
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Sender drops valid and waits for every queued report to come out
	task automatic wait_drained();
		req_if.valid = 1'b0;
		do
			@(negedge clk);
		while (pending_reports.size() != 0);
	endtask

	// Idle point: drained, plus time for a beat that reports nothing
	task automatic settle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register write beat; only called with the block idle
	task automatic cfg_write(input cfg_idx_t idx, input logic [SMP_W-1:0] val);
		cfg_if.index = idx;
		cfg_if.data  = val;
		cfg_if.valid = 1'b1;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		case (idx)
			REG_INV_X:   cfg_inv_x   = val;
			REG_INV_Y:   cfg_inv_y   = val;
			REG_TIMEOUT: cfg_timeout = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid = 1'b0;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Report checking
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : check_reports
		rpt_t want;
		rpt_t got;
		if (arst_n && rpt_if.valid && rpt_if.ready) begin
			got = rpt_if.data;
			if (pending_reports.size() == 0) begin
				$error("report beat with nothing pending: %p", got);
				fail_count++;
			end else begin
				want = pending_reports.pop_front();
				check_field("touch_active", want.touch_active, got.touch_active);
				check_field("has_position", want.has_position, got.has_position);
				check_field("pos_x", want.pos_x, got.pos_x);
				check_field("pos_y", want.pos_y, got.pos_y);
				check_field("pressure", want.pressure, got.pressure);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("touch_sample_pressure_report test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: own stall pattern, plus one long hold-off on request
	// ------------------------------------------------------------------
	initial begin : report_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				// long stretch with ready low so the block backs up into req
				rpt_if.ready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end
			if (!sink_stalls) begin
				rpt_if.ready = 1'b1;
			end else if (stall_left > 0) begin
				rpt_if.ready = 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 3) == 0) begin
				rpt_if.ready = 1'b0;
				stall_left   = $urandom_range(0, 7);
			end else begin
				rpt_if.ready = 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		dir_row_t         directed_rows[$];
		dir_row_t         row;
		req_t             it;
		logic [SMP_W-1:0] set_x, set_y, set_t;
		int               counted;
		int               n_ticks;
		int               sel;

		clk          = 1'b0;
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_INV_X;
		cfg_if.data  = '0;
		rpt_if.ready = 1'b0;

		// Directed table: registers at reset values (no mirror, timeout 70)
		row = '0;
		// tick with the timer idle: nothing
		row.want = WANT_NONE;  row.item = tick_req();
		directed_rows.push_back(row);
		// pen down, data not valid: nothing
		row.item = sample_req(1'b0, 1'b0, 1'b0, 16'd100, 16'd100, 16'd100, 16'd100);
		directed_rows.push_back(row);
		// pen up off the sample line: touch-up, nothing armed
		row.want  = WANT_FIXED;
		row.item  = sample_req(1'b0, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		row.fixed = report(1'b0, 1'b0, 16'd0, 16'd0, 31'd0);
		directed_rows.push_back(row);
		// all zero: q = 0, pressure 2500*1000/1600
		row.item  = sample_req(1'b0, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
		row.fixed = report(1'b1, 1'b1, 16'd0, 16'd0, 31'd1562);
		directed_rows.push_back(row);
		// huge q: pressure goes negative and saturates
		row.item  = sample_req(1'b0, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
		row.fixed = report(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 31'd255);
		directed_rows.push_back(row);
		// most negative q: largest pressure
		row.item  = sample_req(1'b0, 1'b0, 1'b1, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
		row.fixed = report(1'b1, 1'b1, 16'hFFFF, 16'd0, 31'd42521);
		directed_rows.push_back(row);
		// q exactly 2500: pressure 0 turns into 255
		row.item  = sample_req(1'b0, 1'b0, 1'b1, 16'd1, 16'd0, 16'd0, 16'd5002);
		row.fixed = report(1'b1, 1'b1, 16'd1, 16'd0, 31'd255);
		directed_rows.push_back(row);
		// negative numerator: truncation toward zero
		row.want = WANT_MODEL;
		row.item = sample_req(1'b0, 1'b0, 1'b1, 16'hFFFF, 16'd7, 16'hFFFF, 16'hFFFF);
		directed_rows.push_back(row);
		// q = 2498: smallest positive pressure
		row.item = sample_req(1'b0, 1'b0, 1'b1, 16'd1, 16'd3, 16'd0, 16'd4998);
		directed_rows.push_back(row);
		// timeout of two ticks, armed by a pen-up on the sample line
		row = '0;  row.is_cfg = 1'b1;  row.reg_idx = REG_TIMEOUT;  row.reg_val = 16'd2;
		directed_rows.push_back(row);
		row.is_cfg = 1'b0;  row.want = WANT_FIXED;
		row.item   = sample_req(1'b1, 1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
		row.fixed  = report(1'b0, 1'b0, 16'd0, 16'd0, 31'd0);
		directed_rows.push_back(row);
		row.want = WANT_NONE;   row.item = tick_req();
		directed_rows.push_back(row);
		row.want = WANT_FIXED;  // expiry
		directed_rows.push_back(row);
		row.want = WANT_NONE;   // timer has disarmed
		directed_rows.push_back(row);
		// zero timeout acts as one tick
		row = '0;  row.is_cfg = 1'b1;  row.reg_idx = REG_TIMEOUT;  row.reg_val = 16'd0;
		directed_rows.push_back(row);
		row.is_cfg = 1'b0;  row.want = WANT_MODEL;
		row.item   = sample_req(1'b1, 1'b0, 1'b1, 16'd100, 16'd200, 16'd300, 16'd900);
		directed_rows.push_back(row);
		row.want  = WANT_FIXED;  row.item = tick_req();
		row.fixed = report(1'b0, 1'b0, 16'd0, 16'd0, 31'd0);
		directed_rows.push_back(row);
		// mirror both axes, y clamps at zero; the unused index changes nothing
		row = '0;  row.is_cfg = 1'b1;  row.reg_idx = REG_INV_X;   row.reg_val = 16'hFFFF;
		directed_rows.push_back(row);
		row.reg_idx = REG_INV_Y;   row.reg_val = 16'd1000;
		directed_rows.push_back(row);
		row.reg_idx = REG_UNUSED;  row.reg_val = 16'h5A5A;
		directed_rows.push_back(row);
		row.is_cfg = 1'b0;  row.want = WANT_FIXED;
		row.item   = sample_req(1'b1, 1'b0, 1'b1, 16'd0, 16'hFFFF, 16'd0, 16'd0);
		row.fixed  = report(1'b1, 1'b1, 16'hFFFF, 16'd0, 31'd1562);
		directed_rows.push_back(row);
		// invalid pen-down stops the armed timer, so the tick after is silent
		row.want = WANT_NONE;
		row.item = sample_req(1'b0, 1'b0, 1'b0, 16'd1, 16'd1, 16'd1, 16'd1);
		directed_rows.push_back(row);
		row.item = tick_req();
		directed_rows.push_back(row);

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				settle();
				cfg_write(directed_rows[i].reg_idx, directed_rows[i].reg_val);
			end else begin
				send_beat(directed_rows[i].item, directed_rows[i].want,
					directed_rows[i].fixed);
			end
		end

		// Random phases, each under its own register setting
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			settle();
			case (ph)
				0: begin set_x = '0;                set_y = '0;
					set_t = TIMEOUT_RST; end
				1: begin set_x = '1;                set_y = '1;
					set_t = 16'd1; end
				2: begin set_x = SMP_W'($urandom);  set_y = SMP_W'($urandom);
					set_t = SMP_W'($urandom_range(2, 12)); end
				3: begin set_x = 16'd1;             set_y = '0;
					set_t = '0; end
				4: begin set_x = SMP_W'($urandom);  set_y = SMP_W'($urandom);
					set_t = '1; end
				default: begin set_x = SMP_W'($urandom); set_y = '1;
					set_t = SMP_W'($urandom_range(1, 5)); end
			endcase
			cfg_write(REG_INV_X, set_x);
			cfg_write(REG_INV_Y, set_y);
			cfg_write(REG_TIMEOUT, set_t);

			// phase 0 runs flat out on both sides; phase 1 starts with the hold-off
			steady      = (ph == 0);
			sink_stalls = (ph != 0) && (ph != 4);
			if (ph == 1)
				hold_off_req = 1'b1;

			counted = 0;
			while (counted < PHASE_ITEMS) begin
				sel = $urandom_range(0, 99);
				if (sel < 10) begin
					// tick run, sized to reach expiry often
					if (tmr_armed)
						n_ticks = $urandom_range(1, (int'(tmr_left) + 1 > 90) ?
							90 : int'(tmr_left) + 1);
					else
						n_ticks = $urandom_range(1, 2);
					repeat (n_ticks) begin
						counted++;
						send_beat(tick_req(), WANT_MODEL, '0);
					end
				end else begin
					if (sel < 60) begin
						it = rand_sample(1'b0, 1'b1);
					end else if (sel < 78) begin
						it = rand_sample(1'b1, logic'($urandom_range(0, 1)));
					end else if (sel < 88) begin
						it = rand_sample(1'b0, 1'b0);
					end else begin
						// noise: every field fully random
						it.req_type         = logic'($urandom_range(0, 1));
						it.from_sample_line = logic'($urandom_range(0, 1));
						it.pen_up_flag      = logic'($urandom_range(0, 1));
						it.data_valid_flag  = logic'($urandom_range(0, 1));
						it.raw_x            = SMP_W'($urandom);
						it.raw_y            = SMP_W'($urandom);
						it.raw_z1           = SMP_W'($urandom);
						it.raw_z2           = SMP_W'($urandom);
					end
					counted++;
					send_beat(it, WANT_MODEL, '0);
				end
				// now and then the sender waits for the output side to empty
				if ($urandom_range(0, 199) == 0)
					wait_drained();
			end
		end

		settle();
		if (fail_count == 0)
			$display("touch_sample_pressure_report test passed");
		else
			$display("touch_sample_pressure_report test failed");
		$finish;
	end

endmodule
